FILE: src/kbw_pkg.sv
// ----------------------------------------------------------------------------
// kbw_pkg: shared types and constants of the Kaiser-Bessel window core
// Stage record types, fixed-point widths and the Q0.32 polynomial coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package kbw_pkg;

    localparam int WIDTH_BITS   = 32;   // window width and remainder, Q16.16
    localparam int QUO_BITS     = 30;   // t = 2x/W, Q.30 magnitude
    localparam int DIV_CELLS    = QUO_BITS;
    localparam int A_BITS       = 31;   // a = 1 - t*t, Q1.30
    localparam int B_BITS       = 32;   // Horner accumulator, Q0.32
    localparam int HORNER_CELLS = 12;   // eleven coefficient steps and a final multiply
    localparam int VALUE_BITS   = 31;   // window value, Q1.30

    localparam logic [A_BITS-1:0]     Q30_ONE   = A_BITS'(1) << QUO_BITS;
    localparam logic [VALUE_BITS-1:0] VALUE_ONE = VALUE_BITS'(1) << QUO_BITS;

    // Highest-order coefficient seeds the accumulator.
    localparam logic [B_BITS-1:0] COEF_C12 = 32'd9102;

    // Item record moving through the divider cells.
    typedef struct packed {
        logic                  valid;
        logic                  in_win;
        logic [WIDTH_BITS-1:0] rem;
        logic [QUO_BITS-1:0]   quo;
    } t_div_st;

    // Item record moving through the polynomial cells.
    typedef struct packed {
        logic              valid;
        logic              in_win;
        logic [A_BITS-1:0] a;
        logic [B_BITS-1:0] b;
    } t_hor_st;

    // Coefficient added by Horner cell idx: c11 first, c1 next to last,
    // then zero for the closing multiply.
    function automatic logic [B_BITS-1:0] horner_coef(input int idx);
        logic [B_BITS-1:0] c;
        case (idx)
            0:       c = 32'd84996;
            1:       c = 32'd666906;
            2:       c = 32'd4324588;
            3:       c = 32'd22714855;
            4:       c = 32'd94269274;
            5:       c = 32'd299534238;
            6:       c = 32'd699244727;
            7:       c = 32'd1133572855;
            8:       c = 32'd1176114621;
            9:       c = 32'd686392275;
            10:      c = 32'd178037959;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/kaiser_bessel_window_2_5pi_core.sv
// ----------------------------------------------------------------------------
// kaiser_bessel_window_2_5pi_core: modified Kaiser-Bessel window, alpha 2.5*pi
// Fully pipelined window generator, one item per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Each input item is a sample position x (signed Q16.16) measured from the
// window center; each output item is the window amplitude in unsigned Q2.30
// (1.0 = 2^30) on tdata plus an inside flag on tuser. The full window width W
// (unsigned Q16.16, reset 1.0) is set through the write-only config port and
// must only be changed while no item is in flight. A position with 2|x| >= W,
// or any position when W is zero, yields amplitude 0 and flag 0. The core
// takes one item every clock while the output is not stalled; its stages are
// one input register, a row of 30 division cells that produce t = 2|x|/W one
// quotient bit per cell, one squaring stage forming a = 1 - t*t, a row of 12
// Horner cells (one 31x32 multiply each) and the output register. Every stage
// holds its item only while the stage after it is full, so bubbles collapse
// and input keeps flowing while a result waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module kaiser_bessel_window_2_5pi_core
    import kbw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config: window_width
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [WIDTH_BITS-1:0] i_cfg_wr_data,
    // input stream
    input  wire logic                  i_s_axis_tvalid,
    output      logic                  o_s_axis_tready,
    input  wire logic [31:0]           i_s_axis_tdata,   // [31:0] position
    // output stream
    output      logic                  o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output      logic [31:0]           o_m_axis_tdata,   // [30:0] window_value, [31] zero
    output      logic                  o_m_axis_tuser    // [0] inside_res
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [WIDTH_BITS-1:0] r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 32'd65536;
        end else if (i_cfg_wr_en) begin
            r_width <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage load enables, rippling back from the output register
    // ------------------------------------------------------------------
    logic                    in_ld;
    logic [DIV_CELLS-1:0]    div_ld;
    logic                    sq_ld;
    logic [HORNER_CELLS-1:0] hor_ld;
    logic                    out_ld;

    t_div_st div_st [DIV_CELLS];
    t_hor_st hor_st [HORNER_CELLS];

    // ------------------------------------------------------------------
    // Input stage: magnitude, inside test, remainder seed
    // ------------------------------------------------------------------
    logic                  r_in_valid;
    logic                  r_in_inside;
    logic [WIDTH_BITS-1:0] r_in_rem;

    logic [32:0] mag;
    logic [33:0] twice;
    logic        in_win;

    always_comb begin
        // The most negative position gives 2^31 and always falls outside.
        mag    = i_s_axis_tdata[31] ? (33'h1_0000_0000 - {1'b0, i_s_axis_tdata})
                                    : {1'b0, i_s_axis_tdata};
        twice  = {mag, 1'b0};
        in_win = (r_width != '0) && (twice < {2'b00, r_width});
    end

    assign in_ld           = !r_in_valid || div_ld[0];
    assign o_s_axis_tready = in_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ld) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ld && i_s_axis_tvalid) begin
            r_in_inside <= in_win;
            r_in_rem    <= twice[WIDTH_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Division row: t = floor(2|x| * 2^30 / W), one quotient bit per cell
    // ------------------------------------------------------------------
    t_div_st in_st;
    assign in_st = '{valid: r_in_valid, in_win: r_in_inside, rem: r_in_rem, quo: '0};

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        t_div_st prev;
        logic    ld_next;

        if (k == 0) begin : g_first
            assign prev = in_st;
        end else begin : g_rest
            assign prev = div_st[k-1];
        end

        if (k == DIV_CELLS - 1) begin : g_last
            assign ld_next = sq_ld;
        end else begin : g_mid
            assign ld_next = div_ld[k+1];
        end

        kbw_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_width   (r_width),
            .i_prev    (prev),
            .i_ld_next (ld_next),
            .o_ld      (div_ld[k]),
            .o_st      (div_st[k])
        );
    end

    // ------------------------------------------------------------------
    // Squaring stage: a = 1 - (t*t >> 30), seed the accumulator with c12
    // ------------------------------------------------------------------
    logic              r_sq_valid;
    logic              r_sq_inside;
    logic [A_BITS-1:0] r_sq_a;

    logic [2*QUO_BITS-1:0] t_sq;
    logic [A_BITS-1:0]     n_sq_a;

    always_comb begin
        t_sq   = {{QUO_BITS{1'b0}}, div_st[DIV_CELLS-1].quo}
               * {{QUO_BITS{1'b0}}, div_st[DIV_CELLS-1].quo};
        n_sq_a = Q30_ONE - {1'b0, t_sq[2*QUO_BITS-1:QUO_BITS]};
    end

    assign sq_ld = !r_sq_valid || hor_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else if (sq_ld) begin
            r_sq_valid <= div_st[DIV_CELLS-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sq_ld && div_st[DIV_CELLS-1].valid) begin
            r_sq_inside <= div_st[DIV_CELLS-1].in_win;
            r_sq_a      <= n_sq_a;
        end
    end

    t_hor_st sq_st;
    assign sq_st = '{valid: r_sq_valid, in_win: r_sq_inside, a: r_sq_a, b: COEF_C12};

    // ------------------------------------------------------------------
    // Horner row: b = (a*b >> 30) + ck, closing with a bare multiply
    // ------------------------------------------------------------------
    for (genvar k = 0; k < HORNER_CELLS; k++) begin : g_hor
        t_hor_st prev;
        logic    ld_next;

        if (k == 0) begin : g_first
            assign prev = sq_st;
        end else begin : g_rest
            assign prev = hor_st[k-1];
        end

        if (k == HORNER_CELLS - 1) begin : g_last
            assign ld_next = out_ld;
        end else begin : g_mid
            assign ld_next = hor_ld[k+1];
        end

        kbw_horner_cell #(
            .COEF (horner_coef(k))
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_prev    (prev),
            .i_ld_next (ld_next),
            .o_ld      (hor_ld[k]),
            .o_st      (hor_st[k])
        );
    end

    // ------------------------------------------------------------------
    // Output register: round Q0.32 to Q1.30 half up, saturate at 1.0
    // ------------------------------------------------------------------
    logic                  r_out_valid;
    logic                  r_out_inside;
    logic [VALUE_BITS-1:0] r_out_value;

    logic [B_BITS:0]       rnd_sum;
    logic [VALUE_BITS-1:0] rnd;
    logic [VALUE_BITS-1:0] n_value;

    always_comb begin
        rnd_sum = {1'b0, hor_st[HORNER_CELLS-1].b} + (B_BITS+1)'(2);
        rnd     = rnd_sum[B_BITS:2];
        if (!hor_st[HORNER_CELLS-1].in_win) begin
            n_value = '0;
        end else if (rnd > VALUE_ONE) begin
            n_value = VALUE_ONE;
        end else begin
            n_value = rnd;
        end
    end

    assign out_ld = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ld) begin
            r_out_valid <= hor_st[HORNER_CELLS-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld && hor_st[HORNER_CELLS-1].valid) begin
            r_out_inside <= hor_st[HORNER_CELLS-1].in_win;
            r_out_value  <= n_value;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_value};
    assign o_m_axis_tuser  = r_out_inside;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Outside the window the amplitude is forced to zero.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_inside) |-> (r_out_value == '0))
        else $error("nonzero amplitude outside the window");

    // Saturation keeps the amplitude at or below 1.0.
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_value <= VALUE_ONE))
        else $error("amplitude above 1.0");

    // An empty output register lets the whole row advance, so input is taken.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_axis_tready)
        else $error("input stalled while output register empty");

    // A waiting result stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=>
            (r_out_valid && $stable(r_out_value) && $stable(r_out_inside)))
        else $error("waiting result changed or dropped");

endmodule

`default_nettype wire

FILE: src/kbw_div_cell.sv
// ----------------------------------------------------------------------------
// kbw_div_cell: one restoring-division cell
// Shifts the remainder, subtracts the width where it fits, appends a quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module kbw_div_cell
    import kbw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [WIDTH_BITS-1:0] i_width,
    input  wire t_div_st               i_prev,
    input  wire logic                  i_ld_next,
    output      logic                  o_ld,
    output      t_div_st               o_st
);

    logic                  r_valid;
    logic                  r_inside;
    logic [WIDTH_BITS-1:0] r_rem;
    logic [QUO_BITS-1:0]   r_quo;

    logic [WIDTH_BITS:0]   rem2;
    logic [WIDTH_BITS:0]   diff;
    logic                  ge;
    logic [WIDTH_BITS-1:0] n_rem;
    logic [QUO_BITS-1:0]   n_quo;

    // Load when empty or when the item held here moves on.
    assign o_ld = !r_valid || i_ld_next;

    always_comb begin
        rem2  = {i_prev.rem, 1'b0};
        diff  = rem2 - {1'b0, i_width};
        ge    = (rem2 >= {1'b0, i_width});
        n_rem = ge ? diff[WIDTH_BITS-1:0] : rem2[WIDTH_BITS-1:0];
        n_quo = {i_prev.quo[QUO_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ld) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ld && i_prev.valid) begin
            r_inside <= i_prev.in_win;
            r_rem    <= n_rem;
            r_quo    <= n_quo;
        end
    end

    assign o_st = '{valid: r_valid, in_win: r_inside, rem: r_rem, quo: r_quo};

endmodule

`default_nettype wire

FILE: src/kbw_horner_cell.sv
// ----------------------------------------------------------------------------
// kbw_horner_cell: one Horner step of the window polynomial
// Multiplies the accumulator by a, drops 30 fraction bits, adds the cell's coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module kbw_horner_cell
    import kbw_pkg::*;
#(
    parameter logic [B_BITS-1:0] COEF = '0
)
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_hor_st i_prev,
    input  wire logic    i_ld_next,
    output      logic    o_ld,
    output      t_hor_st o_st
);

    logic              r_valid;
    logic              r_inside;
    logic [A_BITS-1:0] r_a;
    logic [B_BITS-1:0] r_b;

    logic [A_BITS+B_BITS-1:0] prod;
    logic [B_BITS-1:0]        n_b;

    assign o_ld = !r_valid || i_ld_next;

    // a never exceeds 1.0, so the shifted product fits the accumulator.
    always_comb begin
        prod = {{B_BITS{1'b0}}, i_prev.a} * {{A_BITS{1'b0}}, i_prev.b};
        n_b  = prod[QUO_BITS+B_BITS-1:QUO_BITS] + COEF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ld) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ld && i_prev.valid) begin
            r_inside <= i_prev.in_win;
            r_a      <= i_prev.a;
            r_b      <= n_b;
        end
    end

    assign o_st = '{valid: r_valid, in_win: r_inside, a: r_a, b: r_b};

endmodule

`default_nettype wire
